FILE: rtl/gap_buffer_engine_top_macros.svh
// Assertion macros for the gap buffer engine top level.
// No dependencies; the including module must provide i_clk and i_rst_n.
`ifndef GAP_BUFFER_ENGINE_TOP_MACROS_SVH
`define GAP_BUFFER_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define GBE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define GBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gbe_pkg.sv
// Shared types and constants for the gap buffer engine.
// No dependencies; used by the controller, datapath and top level.
package gbe_pkg;

    localparam int FUNC_W = 2;
    localparam int POS_W  = 10;
    localparam int CHAR_W = 8;
    localparam int STAT_W = 2;
    localparam int VAL_W  = 10;

    typedef enum logic [FUNC_W-1:0] {
        FN_GOTO   = 2'd0,
        FN_INSERT = 2'd1,
        FN_REMOVE = 2'd2,
        FN_GET    = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_MOVE,
        S_MOVE_RD,
        S_READ,
        S_INS_MV,
        S_INS_CH,
        S_RM_CHK,
        S_RM_WR
    } t_state;

    // Read address select
    typedef enum logic [1:0] {
        RD_NONE,
        RD_CURSOR,
        RD_CUR_GAP1,
        RD_GET
    } t_rd_sel;

    // Write select (gap moves are handled by the datapath's pending write)
    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT,
        WR_CUR1_RD,
        WR_CUR_CHAR,
        WR_CUR_RD
    } t_wr_sel;

    // Result value select
    typedef enum logic [1:0] {
        V_ZERO,
        V_RD,
        V_CUR_INC,
        V_SAVED
    } t_val_sel;

    typedef struct packed {
        logic     latch;
        t_rd_sel  rd_sel;
        t_wr_sel  wr_sel;
        logic     step;
        logic     ins_upd;
        logic     rm_upd;
        logic     save_char;
        logic     res_load;
        t_status  res_status;
        t_val_sel res_val;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  pos_range;
        logic  gap_zero;
        logic  at_target;
        logic  rd_zero;
        logic  count_lt2;
    } t_dp_stat;

endpackage

FILE: rtl/gap_buffer_engine_top.sv
// Gap buffer engine top level: controller plus datapath, with assertions.
// Depends on gbe_pkg, gbe_ctrl, gbe_dp and gap_buffer_engine_top_macros.svh.
//
// One text line in a gap buffer of CAPACITY bytes, ending in a zero
// terminator. A word is taken when start is high and busy is low; each word
// gives exactly one result, shown for one cycle with o_valid high, and the
// receiver cannot stall it. Range and buffer-full errors are answered from
// the decode state, get and a refused remove after a character read, insert
// and remove after their RAM accesses, and goto after the gap has moved to
// the target and the new cursor character is read. Insert takes one read
// and two writes, and remove two reads and one write, on the single-read,
// single-write character RAM; goto moves one character across the gap per
// cycle through a read-then-write pipeline on that RAM. busy is already low
// in the cycle o_valid is high. After reset, busy stays high for one cycle
// while the terminator is written.
module gap_buffer_engine_top #(
    parameter int CAPACITY = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [gbe_pkg::FUNC_W-1:0] i_func,
    input  logic [gbe_pkg::POS_W-1:0]  i_position,
    input  logic [gbe_pkg::CHAR_W-1:0] i_char_in,
    output logic                       o_valid,
    output logic [gbe_pkg::STAT_W-1:0] o_status,
    output logic [gbe_pkg::VAL_W-1:0]  o_value
);
    import gbe_pkg::*;

    `include "gap_buffer_engine_top_macros.svh"

    t_dp_cmd  cmd;
    t_dp_stat stat;

    gbe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    gbe_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_func     (i_func),
        .i_position (i_position),
        .i_char_in  (i_char_in),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_value    (o_value)
    );

    // Accepted word keeps the engine busy until its result is produced
    `GBE_ASSERT_NEXT(a_start_busy, start && !busy, busy, "busy not raised after start")
    // Result strobe only when the engine is back to idle
    `GBE_ASSERT_SAME(a_valid_idle, o_valid, !busy, "result while still busy")
    // Error results carry a zero value
    `GBE_ASSERT_SAME(a_err_zero, o_valid && (o_status != ST_OK), o_value == '0,
        "error result with nonzero value")
    // At most one result per word: strobes never back to back
    `GBE_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "back-to-back result strobes")

endmodule

FILE: rtl/gbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gbe_dp.sv
// Datapath: character store, cursor/gap/count registers, result register.
// Depends on gbe_pkg and gbe_ram; driven by gbe_ctrl commands.
module gbe_dp #(
    parameter int CAPACITY = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [gbe_pkg::FUNC_W-1:0]    i_func,
    input  logic [gbe_pkg::POS_W-1:0]     i_position,
    input  logic [gbe_pkg::CHAR_W-1:0]    i_char_in,
    input  gbe_pkg::t_dp_cmd              i_cmd,
    output gbe_pkg::t_dp_stat             o_stat,
    output logic                          o_valid,
    output logic [gbe_pkg::STAT_W-1:0]    o_status,
    output logic [gbe_pkg::VAL_W-1:0]     o_value
);
    import gbe_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = AW + 1;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // Latched word
    t_func             r_func;
    logic [POS_W-1:0]  r_pos;
    logic [CHAR_W-1:0] r_char;

    // Buffer geometry
    logic [AW-1:0]     r_cursor;
    logic [CW-1:0]     r_gap;
    logic [CW-1:0]     r_count;

    // Gap move write pipeline and saved byte
    logic              r_wpend;
    logic [AW-1:0]     r_waddr;
    logic [CHAR_W-1:0] r_saved;

    // Result register
    logic              r_valid;
    t_status           r_status;
    logic [VAL_W-1:0]  r_value;

    logic [CMPW-1:0]   pos_c;
    logic [CMPW-1:0]   cur_c;
    logic [CMPW-1:0]   cnt_c;
    logic [AW-1:0]     pos_a;
    logic [AW-1:0]     cur1_a;
    logic [AW-1:0]     cur_gap_a;
    logic [AW-1:0]     cur_gap1_a;
    logic [AW-1:0]     get_a;
    logic              move_right;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [CHAR_W-1:0] rd_data;
    logic [VAL_W-1:0]  res_value;

    // Address arithmetic
    assign pos_c      = CMPW'(r_pos);
    assign cur_c      = CMPW'(r_cursor);
    assign cnt_c      = CMPW'(r_count);
    assign pos_a      = AW'(r_pos);
    assign cur1_a     = AW'({1'b0, r_cursor} + CW'(1));
    assign cur_gap_a  = AW'({1'b0, r_cursor} + r_gap);
    assign cur_gap1_a = AW'({1'b0, r_cursor} + r_gap + CW'(1));
    assign get_a      = (pos_c > cur_c) ? AW'({1'b0, pos_a} + r_gap) : pos_a;
    assign move_right = (cur_c < pos_c);

    // Status to controller
    assign o_stat.func      = r_func;
    assign o_stat.pos_range = (pos_c >= cnt_c);
    assign o_stat.gap_zero  = (r_gap == '0);
    assign o_stat.at_target = (cur_c == pos_c);
    assign o_stat.rd_zero   = (rd_data == '0);
    assign o_stat.count_lt2 = (r_count < CW'(2));

    // Read port select; a gap step reads the character that crosses the gap
    always_comb begin
        re    = 1'b0;
        raddr = '0;
        if (i_cmd.step) begin
            re    = 1'b1;
            raddr = move_right ? cur_gap1_a : r_cursor;
        end else begin
            case (i_cmd.rd_sel)
                RD_CURSOR: begin
                    re    = 1'b1;
                    raddr = r_cursor;
                end
                RD_CUR_GAP1: begin
                    re    = 1'b1;
                    raddr = cur_gap1_a;
                end
                RD_GET: begin
                    re    = 1'b1;
                    raddr = get_a;
                end
                default: begin
                    re    = 1'b0;
                    raddr = '0;
                end
            endcase
        end
    end

    // Write port select; pending gap-move write has priority
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = rd_data;
        if (r_wpend) begin
            we    = 1'b1;
            waddr = r_waddr;
        end else begin
            case (i_cmd.wr_sel)
                WR_INIT: begin
                    we    = 1'b1;
                    wdata = '0;
                end
                WR_CUR1_RD: begin
                    we    = 1'b1;
                    waddr = cur1_a;
                end
                WR_CUR_CHAR: begin
                    we    = 1'b1;
                    waddr = r_cursor;
                    wdata = r_char;
                end
                WR_CUR_RD: begin
                    we    = 1'b1;
                    waddr = r_cursor;
                end
                default: begin
                    we    = 1'b0;
                end
            endcase
        end
    end

    gbe_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // Result value select
    always_comb begin
        case (i_cmd.res_val)
            V_RD:      res_value = VAL_W'(rd_data);
            V_CUR_INC: res_value = VAL_W'({1'b0, r_cursor} + CW'(1));
            V_SAVED:   res_value = VAL_W'(r_saved);
            default:   res_value = '0;
        endcase
    end

    // Control state: geometry, write pipeline flag, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_gap    <= CW'(CAPACITY - 1);
            r_count  <= CW'(1);
            r_wpend  <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_wpend <= i_cmd.step;
            r_valid <= i_cmd.res_load;
            if (i_cmd.step) begin
                r_cursor <= move_right ? cur1_a : AW'({1'b0, r_cursor} - CW'(1));
            end else if (i_cmd.ins_upd) begin
                r_cursor <= cur1_a;
                r_count  <= r_count + CW'(1);
                r_gap    <= r_gap - CW'(1);
            end else if (i_cmd.rm_upd) begin
                r_count  <= r_count - CW'(1);
                r_gap    <= r_gap + CW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= t_func'(i_func);
            r_pos  <= i_position;
            r_char <= i_char_in;
        end
        if (i_cmd.step) begin
            r_waddr <= move_right ? cur1_a : cur_gap_a;
        end
        if (i_cmd.save_char) begin
            r_saved <= rd_data;
        end
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_status;
            r_value  <= res_value;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_value  = r_value;

endmodule

FILE: rtl/gbe_ctrl.sv
// Controller state machine: sequences each operation on the datapath.
// Depends on gbe_pkg; drives gbe_dp through a command struct.
module gbe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  gbe_pkg::t_dp_stat i_stat,
    output gbe_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import gbe_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register; reset goes through a one-cycle terminator write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.func)
                    FN_GOTO:   n_state = i_stat.pos_range ? S_IDLE : S_MOVE;
                    FN_INSERT: n_state = i_stat.gap_zero ? S_IDLE : S_INS_MV;
                    FN_REMOVE: n_state = S_RM_CHK;
                    FN_GET:    n_state = i_stat.pos_range ? S_IDLE : S_READ;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_MOVE: begin
                if (i_stat.at_target) begin
                    n_state = S_MOVE_RD;
                end
            end
            S_MOVE_RD: n_state = S_READ;
            S_READ:    n_state = S_IDLE;
            S_INS_MV:  n_state = S_INS_CH;
            S_INS_CH:  n_state = S_IDLE;
            S_RM_CHK: begin
                if (i_stat.rd_zero || i_stat.count_lt2) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RM_WR;
                end
            end
            S_RM_WR:   n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.rd_sel     = RD_NONE;
        o_cmd.wr_sel     = WR_NONE;
        o_cmd.res_status = ST_OK;
        o_cmd.res_val    = V_ZERO;
        case (r_state)
            S_INIT: o_cmd.wr_sel = WR_INIT;
            S_IDLE: o_cmd.latch = i_start;
            S_DECODE: begin
                case (i_stat.func)
                    FN_GOTO: begin
                        if (i_stat.pos_range) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_RANGE;
                        end
                    end
                    FN_INSERT: begin
                        if (i_stat.gap_zero) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.rd_sel = RD_CURSOR;
                        end
                    end
                    FN_REMOVE: o_cmd.rd_sel = RD_CURSOR;
                    FN_GET: begin
                        if (i_stat.pos_range) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_RANGE;
                        end else begin
                            o_cmd.rd_sel = RD_GET;
                        end
                    end
                    default: o_cmd.rd_sel = RD_NONE;
                endcase
            end
            // one character crosses the gap per cycle
            S_MOVE:    o_cmd.step = !i_stat.at_target;
            S_MOVE_RD: o_cmd.rd_sel = RD_CURSOR;
            S_READ: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_val  = V_RD;
            end
            S_INS_MV: o_cmd.wr_sel = WR_CUR1_RD;
            S_INS_CH: begin
                o_cmd.wr_sel   = WR_CUR_CHAR;
                o_cmd.ins_upd  = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_val  = V_CUR_INC;
            end
            S_RM_CHK: begin
                if (i_stat.rd_zero || i_stat.count_lt2) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_EMPTY;
                end else begin
                    o_cmd.save_char = 1'b1;
                    o_cmd.rd_sel    = RD_CUR_GAP1;
                end
            end
            S_RM_WR: begin
                o_cmd.wr_sel   = WR_CUR_RD;
                o_cmd.rm_upd   = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_val  = V_SAVED;
            end
            default: o_cmd.latch = 1'b0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
